### hdl/word_frequency_counter_unit_assert.svh
// Assertion macros shared by the word frequency counter RTL.
`ifndef WORD_FREQUENCY_COUNTER_UNIT_ASSERT_SVH
`define WORD_FREQUENCY_COUNTER_UNIT_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define WFC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define WFC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define WFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/wfc_pkg.sv
// Shared constants and helpers of the word frequency counter.
package wfc_pkg;

  // Width and saturation limit of the occurrence and word counters.
  localparam int unsigned CountW = 11;
  localparam logic [CountW-1:0] CountMax = '1;

  // Byte codes that separate words.
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;

  // True for space, tab, newline, vertical tab, form feed and carriage return.
  function automatic logic is_space(input logic [7:0] c);
    return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  endfunction

  // Saturating increment of a counter.
  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    return (v == CountMax) ? v : v + CountW'(1);
  endfunction

endpackage

### hdl/wfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wfc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/word_frequency_counter_unit.sv
// Top level of the word frequency counter: byte intake, table scan sequencer, result register.
//
//  channel  direction  handshake                 payload
//  input    in         in_valid_i / in_ready_o   text_byte_i, end_of_text_i
//  output   out        out_valid_o / out_ready_i word_valid_o .. text_end_o
//
// A byte that closes no word is taken in the idle state. A closing word scans the
// table entry by entry (length read in S_SCAN, compare in S_LCMP), and for every
// entry whose stored length matches compares it byte by byte (S_BREQ, S_BCMP). A miss
// at the end of the table copies the new word into the store byte by byte (S_COPY_RD,
// S_COPY_WR) if there is room, and S_EMIT hands the result over.
// The scan shares one byte comparator and one store address adder.
// No clearing pass follows reset; the fill count marks the live entries.
// The block accepts no byte while a word is being looked up, and holds the
// finished result until the output transfer takes place.
module word_frequency_counter_unit #(
  parameter int unsigned MAX_ENTRIES = 128,
  parameter int unsigned WORD_CHARS  = 64,
  parameter int unsigned TEXT_BYTES  = 2048,
  parameter int unsigned SlotW = $clog2(MAX_ENTRIES),
  parameter int unsigned UniqW = $clog2(MAX_ENTRIES + 1),
  parameter int unsigned PosW  = $clog2(TEXT_BYTES),
  parameter int unsigned LenW  = $clog2(TEXT_BYTES + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     text_byte_i,
  input  logic                           end_of_text_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           word_valid_o,
  output logic [SlotW-1:0]               slot_o,
  output logic                           is_new_o,
  output logic [PosW-1:0]                word_begin_o,
  output logic [LenW-1:0]                word_length_o,
  output logic [wfc_pkg::CountW-1:0]     word_count_o,
  output logic [UniqW-1:0]               unique_words_o,
  output logic [wfc_pkg::CountW-1:0]     total_words_o,
  output logic [LenW-1:0]                bytes_seen_o,
  output logic                           table_full_o,
  output logic                           word_truncated_o,
  output logic                           text_end_o
);

  localparam int unsigned KW   = $clog2(WORD_CHARS + 1);
  localparam int unsigned CwAw = $clog2(WORD_CHARS);
  localparam int unsigned SwD  = MAX_ENTRIES * WORD_CHARS;
  localparam int unsigned SwAw = $clog2(SwD);
  localparam int unsigned CW   = wfc_pkg::CountW;

  // Sequencer states.
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN    = 3'd1;
  localparam logic [2:0] S_LCMP    = 3'd2;
  localparam logic [2:0] S_BREQ    = 3'd3;
  localparam logic [2:0] S_BCMP    = 3'd4;
  localparam logic [2:0] S_COPY_RD = 3'd5;
  localparam logic [2:0] S_COPY_WR = 3'd6;
  localparam logic [2:0] S_EMIT    = 3'd7;

  logic [2:0]      state_q;
  logic [UniqW-1:0] e_q;        // entry under test
  logic [SwAw-1:0] base_q;      // store address of that entry's first byte
  logic [KW-1:0]   k_q;         // byte index within the word
  logic [KW-1:0]   stored_q;    // bytes kept of the closing word
  logic [LenW-1:0] chars_q;     // full length of the open word
  logic [PosW-1:0] start_q;
  logic [LenW-1:0] bpos_q;
  logic            inside_q;
  logic [UniqW-1:0] used_q;
  logic [CW-1:0]   total_q;
  logic            end_q;

  // Result fields that depend on the table lookup.
  logic             res_word_q;
  logic [SlotW-1:0] res_slot_q;
  logic             res_new_q;
  logic [CW-1:0]    res_cnt_q;
  logic             res_full_q;

  // Intake decode. A byte only counts while the text buffer has room.
  logic            accept;
  logic            in_buf;
  logic            sp;
  logic            grows;
  logic            inside_nx;
  logic            closes;
  logic [LenW-1:0] chars_nx;
  logic [KW-1:0]   stored_nx;
  logic            emit_go;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign in_buf     = (32'(bpos_q) < TEXT_BYTES);
  assign sp         = wfc_pkg::is_space(text_byte_i);
  assign grows      = in_buf && !sp;
  assign inside_nx  = inside_q || grows;
  assign closes     = (in_buf && sp && inside_q) || (end_of_text_i && inside_nx);
  assign chars_nx   = !grows ? chars_q : (inside_q ? chars_q + LenW'(1) : LenW'(1));
  assign stored_nx  = (32'(chars_nx) < WORD_CHARS) ? KW'(chars_nx) : KW'(WORD_CHARS);

  // A finished result moves into the output register when that register is free.
  assign emit_go    = (state_q == S_EMIT) && (!out_valid_o || out_ready_i);

  // Memories: the open word, the word store, and per-entry length and count.
  logic            cw_we;
  logic [CwAw-1:0] cw_wa;
  logic [7:0]      cw_rd;
  logic [SwAw-1:0] ws_addr;
  logic [7:0]      ws_rd;
  logic [KW-1:0]   len_rd;
  logic [CW-1:0]   cnt_rd;
  logic            last_byte;
  logic            copy_last;
  logic            hit_last;
  logic [CW-1:0]   cnt_wd;

  assign cw_we = accept && grows && (!inside_q || (32'(chars_q) < WORD_CHARS));
  assign cw_wa = inside_q ? chars_q[CwAw-1:0] : '0;

  assign ws_addr   = base_q + SwAw'(k_q);
  assign last_byte = ((k_q + KW'(1)) == stored_q);
  assign copy_last = (state_q == S_COPY_WR) && last_byte;
  assign hit_last  = (state_q == S_BCMP) && (cw_rd == ws_rd) && last_byte;
  assign cnt_wd    = copy_last ? CW'(1) : wfc_pkg::sat_inc(cnt_rd);

  wfc_ram #(.WIDTH(8), .DEPTH(WORD_CHARS)) u_cw_ram (
    .clk_i   (clk_i),
    .we_i    (cw_we),
    .waddr_i (cw_wa),
    .wdata_i (text_byte_i),
    .raddr_i (k_q[CwAw-1:0]),
    .rdata_o (cw_rd)
  );

  wfc_ram #(.WIDTH(8), .DEPTH(SwD)) u_ws_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == S_COPY_WR),
    .waddr_i (ws_addr),
    .wdata_i (cw_rd),
    .raddr_i (ws_addr),
    .rdata_o (ws_rd)
  );

  wfc_ram #(.WIDTH(KW), .DEPTH(MAX_ENTRIES)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (copy_last),
    .waddr_i (e_q[SlotW-1:0]),
    .wdata_i (stored_q),
    .raddr_i (e_q[SlotW-1:0]),
    .rdata_o (len_rd)
  );

  wfc_ram #(.WIDTH(CW), .DEPTH(MAX_ENTRIES)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (copy_last || hit_last),
    .waddr_i (e_q[SlotW-1:0]),
    .wdata_i (cnt_wd),
    .raddr_i (e_q[SlotW-1:0]),
    .rdata_o (cnt_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      e_q              <= '0;
      base_q           <= '0;
      k_q              <= '0;
      stored_q         <= '0;
      chars_q          <= '0;
      start_q          <= '0;
      bpos_q           <= '0;
      inside_q         <= 1'b0;
      used_q           <= '0;
      total_q          <= '0;
      end_q            <= 1'b0;
      res_word_q       <= 1'b0;
      res_slot_q       <= '0;
      res_new_q        <= 1'b0;
      res_cnt_q        <= '0;
      res_full_q       <= 1'b0;
      out_valid_o      <= 1'b0;
      word_valid_o     <= 1'b0;
      slot_o           <= '0;
      is_new_o         <= 1'b0;
      word_count_o     <= '0;
      table_full_o     <= 1'b0;
      word_begin_o     <= '0;
      word_length_o    <= '0;
      word_truncated_o <= 1'b0;
      unique_words_o   <= '0;
      total_words_o    <= '0;
      bytes_seen_o     <= '0;
      text_end_o       <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            end_q <= end_of_text_i;
            if (in_buf) begin
              bpos_q <= bpos_q + LenW'(1);
            end
            if (grows && !inside_q) begin
              start_q <= bpos_q[PosW-1:0];
            end
            chars_q  <= chars_nx;
            stored_q <= stored_nx;
            e_q      <= '0;
            base_q   <= '0;
            k_q      <= '0;
            if (closes) begin
              // The word ends here: count it and look it up in the table.
              inside_q <= 1'b0;
              total_q  <= wfc_pkg::sat_inc(total_q);
              state_q  <= S_SCAN;
            end else begin
              inside_q <= inside_nx;
              if (end_of_text_i) begin
                // End of text with no open word gives a bare end result.
                res_word_q <= 1'b0;
                res_slot_q <= '0;
                res_new_q  <= 1'b0;
                res_cnt_q  <= '0;
                res_full_q <= 1'b0;
                state_q    <= S_EMIT;
              end
            end
          end
        end
        S_SCAN: begin
          k_q <= '0;
          if (e_q == used_q) begin
            res_word_q <= 1'b1;
            if (32'(used_q) < MAX_ENTRIES) begin
              state_q <= S_COPY_RD;
            end else begin
              res_slot_q <= '0;
              res_new_q  <= 1'b0;
              res_cnt_q  <= '0;
              res_full_q <= 1'b1;
              state_q    <= S_EMIT;
            end
          end else begin
            state_q <= S_LCMP;
          end
        end
        S_LCMP: begin
          if (len_rd == stored_q) begin
            state_q <= S_BREQ;
          end else begin
            e_q     <= e_q + UniqW'(1);
            base_q  <= base_q + SwAw'(WORD_CHARS);
            state_q <= S_SCAN;
          end
        end
        S_BREQ: begin
          state_q <= S_BCMP;
        end
        S_BCMP: begin
          if (cw_rd != ws_rd) begin
            e_q     <= e_q + UniqW'(1);
            base_q  <= base_q + SwAw'(WORD_CHARS);
            state_q <= S_SCAN;
          end else if (last_byte) begin
            res_word_q <= 1'b1;
            res_slot_q <= e_q[SlotW-1:0];
            res_new_q  <= 1'b0;
            res_cnt_q  <= cnt_wd;
            res_full_q <= 1'b0;
            state_q    <= S_EMIT;
          end else begin
            k_q     <= k_q + KW'(1);
            state_q <= S_BREQ;
          end
        end
        S_COPY_RD: begin
          state_q <= S_COPY_WR;
        end
        S_COPY_WR: begin
          if (last_byte) begin
            used_q     <= used_q + UniqW'(1);
            res_slot_q <= e_q[SlotW-1:0];
            res_new_q  <= 1'b1;
            res_cnt_q  <= cnt_wd;
            res_full_q <= 1'b0;
            state_q    <= S_EMIT;
          end else begin
            k_q     <= k_q + KW'(1);
            state_q <= S_COPY_RD;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            word_valid_o     <= res_word_q;
            slot_o           <= res_slot_q;
            is_new_o         <= res_new_q;
            word_count_o     <= res_cnt_q;
            table_full_o     <= res_full_q;
            word_begin_o     <= res_word_q ? start_q : '0;
            word_length_o    <= res_word_q ? chars_q : '0;
            word_truncated_o <= res_word_q && (32'(chars_q) > WORD_CHARS);
            unique_words_o   <= used_q;
            total_words_o    <= total_q;
            bytes_seen_o     <= bpos_q;
            text_end_o       <= end_q;
            if (end_q) begin
              // The text is over: the next byte opens a fresh table.
              used_q   <= '0;
              bpos_q   <= '0;
              start_q  <= '0;
              chars_q  <= '0;
              total_q  <= '0;
              inside_q <= 1'b0;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `include "word_frequency_counter_unit_assert.svh"

  // The fill count never passes the table size.
  `WFC_ASSERT_ALWAYS(a_used_bound, 32'(used_q) <= MAX_ENTRIES, "entry count exceeds table size")
  // The scan never runs past the filled part of the table.
  `WFC_ASSERT_IMPL(a_scan_bound, state_q == S_SCAN, e_q <= used_q, "scan passed the fill count")
  // A word under lookup always has at least one stored byte.
  `WFC_ASSERT_IMPL(a_stored_nz, state_q == S_LCMP, stored_q != '0, "empty word in lookup")
  // A result that leaves the sequencer shows up on the output next cycle.
  `WFC_ASSERT_NEXT(a_emit_out, emit_go, out_valid_o, "result lost")

endmodule
